[src/gkg_pkg.sv]
// ----------------------------------------------------------------------------
// gkg_pkg
// Shared types and constants of the gaussian kernel generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gkg_pkg;

    localparam int MAX_TAPS_DEF = 32;

    localparam int IDX_W   = 5;
    localparam int SIZE_W  = 6;
    localparam int SCALE_W = 20;
    localparam int DIMS_W  = 2;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 20;
    localparam int TAP_W   = 17;
    localparam int RAW_W   = 31;
    localparam int MUL_W   = 32;

    localparam int TAYLOR_TERMS = 12;

    localparam logic [RAW_W-1:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [MUL_W-1:0] E_INV_Q30 = 32'd395007542;

    localparam logic [SCALE_W-1:0] EXP_SCALE_RST   = 20'd31457;
    localparam logic [SIZE_W-1:0]  KERNEL_SIZE_RST = 6'd5;
    localparam logic [DIMS_W-1:0]  DIMENSIONS_RST  = 2'd1;

    typedef enum logic [0:0] {
        OP_BUILD = 1'b0,
        OP_READ  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_BUILT = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef enum logic [CFG_IW-1:0] {
        CFG_KERNEL_SIZE = 2'd0,
        CFG_EXP_SCALE   = 2'd1,
        CFG_DIMENSIONS  = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_BINIT,
        DP_MUL_DD,
        DP_MUL_T,
        DP_LOAD_T,
        DP_MUL_EN,
        DP_EN_WB,
        DP_MUL_TX,
        DP_DIV_TERM,
        DP_TERM_WB,
        DP_MUL_V,
        DP_V_WB,
        DP_NINIT,
        DP_DIV_NORM,
        DP_NORM_WB,
        DP_BDONE,
        DP_RCHK,
        DP_P_LOAD,
        DP_MUL_P,
        DP_P_WB
    } t_dp_op;

    typedef enum logic [1:0] {
        RA_TAP,
        RA_I,
        RA_J,
        RA_K
    } t_ra_sel;

    typedef struct packed {
        t_dp_op  op;
        t_ra_sel ra;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic n_stop;
        logic k_last;
        logic i_last;
        logic div_done;
        logic rd_err;
        logic use_j;
        logic use_k;
    } t_dp_sts;

endpackage

`default_nettype wire

[src/gkg_ram.sv]
// ----------------------------------------------------------------------------
// gkg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gkg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/gkg_div.sv]
// ----------------------------------------------------------------------------
// gkg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gkg_div #(
    parameter int NUM_W = 53,
    parameter int DEN_W = 36
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quo,
    output logic                  o_done
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        rem_sh = {r_rem, r_num[NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        n_rem  = ge ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[NUM_W-2:0], ge};
        end
    end

    assign o_quo  = r_num;
    assign o_done = r_done;

endmodule

`default_nettype wire

[src/gkg_dp.sv]
// ----------------------------------------------------------------------------
// gkg_dp
// Datapath: config registers, tap arithmetic, tap table and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gkg_dp #(
    parameter int MAX_TAPS = gkg_pkg::MAX_TAPS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    input  wire logic [gkg_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [gkg_pkg::CFG_DW-1:0]  i_cfg_data,
    input  wire logic [gkg_pkg::IDX_W-1:0]   i_index_i,
    input  wire logic [gkg_pkg::IDX_W-1:0]   i_index_j,
    input  wire logic [gkg_pkg::IDX_W-1:0]   i_index_k,
    input  wire gkg_pkg::t_dp_cmd            i_cmd,
    output gkg_pkg::t_dp_sts                 o_sts,
    output logic      [gkg_pkg::TAP_W-1:0]   o_coefficient,
    output logic      [1:0]                  o_status
);

    import gkg_pkg::*;

    localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int SW   = $clog2(MAX_TAPS + 1);
    localparam int DDW  = 2 * SW;
    localparam int TW   = DDW + SCALE_W;
    localparam int NW   = TW - 16;
    localparam int SUMW = RAW_W - 1 + SW;
    localparam int DNW  = SUMW + 17;
    localparam int CW   = SW + IDX_W;

    // config registers
    logic [SIZE_W-1:0]  r_ks;
    logic [SCALE_W-1:0] r_scale;
    logic [DIMS_W-1:0]  r_dims;

    logic               r_ready;
    logic [SW-1:0]      r_built;

    logic [IDX_W-1:0]   r_ii, r_ij, r_ik;
    logic [DIMS_W-1:0]  r_dim;
    logic [SW-1:0]      r_size;
    logic [SW-1:0]      r_i;
    logic [2*MUL_W-1:0] r_prod;
    logic [NW-1:0]      r_n;
    logic [29:0]        r_x;
    logic [RAW_W-1:0]   r_en, r_er, r_term;
    logic [3:0]         r_k;
    logic [SUMW-1:0]    r_sum;
    logic [TAP_W-1:0]   r_p;
    t_status            r_st;
    logic [TAP_W-1:0]   r_coef;
    t_status            r_status;

    logic [SW-1:0]      size_c;
    logic [SW:0]        half;
    logic [SW-1:0]      ctr;
    logic [SW-1:0]      ad;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_res;
    logic [RAW_W-1:0]   rnd30;
    logic [TAP_W-1:0]   rnd16;
    logic [RAW_W-1:0]   quo31;
    logic [MUL_W-1:0]   rcp_m;
    logic [2:0]         rcp_sh;

    logic               div_start;
    logic [DNW-1:0]     div_num;
    logic [SUMW-1:0]    div_den;
    logic [DNW-1:0]     div_quo;
    logic               div_done;

    logic               ram_we;
    logic [RAW_W-1:0]   ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [RAW_W-1:0]   ram_rdata;
    logic [AW+IDX_W-1:0] ext_i, ext_j, ext_k;

    logic               oob_i, oob_j, oob_k, rng_err;

    // clamp of the requested size
    always_comb begin
        if (r_ks == '0) begin
            size_c = SW'(1);
        end else if (int'(r_ks) > MAX_TAPS) begin
            size_c = SW'(MAX_TAPS);
        end else begin
            size_c = SW'(r_ks);
        end
    end

    // distance of the current tap from the center
    always_comb begin
        half = ({1'b0, r_size} + (SW+1)'(1)) >> 1;
        ctr  = SW'(half - (SW+1)'(1));
        ad   = (r_i >= ctr) ? (r_i - ctr) : (ctr - r_i);
    end

    // reciprocal of the term index, exact floor for numerators below 2^30
    // quotient is (a * m) >> (30 + sh)
    always_comb begin
        case (r_k)
            4'd2:    begin rcp_m = 32'd1073741824; rcp_sh = 3'd1; end
            4'd3:    begin rcp_m = 32'd1431655766; rcp_sh = 3'd2; end
            4'd4:    begin rcp_m = 32'd1073741824; rcp_sh = 3'd2; end
            4'd5:    begin rcp_m = 32'd1717986919; rcp_sh = 3'd3; end
            4'd6:    begin rcp_m = 32'd1431655766; rcp_sh = 3'd3; end
            4'd7:    begin rcp_m = 32'd1227133514; rcp_sh = 3'd3; end
            4'd8:    begin rcp_m = 32'd1073741824; rcp_sh = 3'd3; end
            4'd9:    begin rcp_m = 32'd1908874354; rcp_sh = 3'd4; end
            4'd10:   begin rcp_m = 32'd1717986919; rcp_sh = 3'd4; end
            4'd11:   begin rcp_m = 32'd1561806290; rcp_sh = 3'd4; end
            4'd12:   begin rcp_m = 32'd1431655766; rcp_sh = 3'd4; end
            default: begin rcp_m = 32'd1073741824; rcp_sh = 3'd0; end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            DP_MUL_DD: begin
                mul_a = MUL_W'(ad);
                mul_b = MUL_W'(ad);
            end
            DP_MUL_T: begin
                mul_a = MUL_W'(r_prod[DDW-1:0]);
                mul_b = MUL_W'(r_scale);
            end
            DP_MUL_EN: begin
                mul_a = MUL_W'(r_en);
                mul_b = E_INV_Q30;
            end
            DP_MUL_TX: begin
                mul_a = MUL_W'(r_term);
                mul_b = MUL_W'(r_x);
            end
            DP_DIV_TERM: begin
                mul_a = MUL_W'(r_prod[60:30]);
                mul_b = rcp_m;
            end
            DP_MUL_V: begin
                mul_a = MUL_W'(r_en);
                mul_b = MUL_W'(r_er);
            end
            DP_MUL_P: begin
                mul_a = MUL_W'(r_p);
                mul_b = MUL_W'(ram_rdata[TAP_W-1:0]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_res = mul_a * mul_b;
    assign rnd30   = RAW_W'((r_prod + (2*MUL_W)'(64'd536870912)) >> 30);
    assign rnd16   = TAP_W'((r_prod + (2*MUL_W)'(64'd32768)) >> 16);
    assign quo31   = RAW_W'(r_prod >> (7'd30 + 7'(rcp_sh)));

    // divider operands, normalization only
    assign div_start = (i_cmd.op == DP_DIV_NORM);
    assign div_num   = DNW'({ram_rdata, 16'b0}) + DNW'(r_sum >> 1);
    assign div_den   = r_sum;

    gkg_div #(
        .NUM_W (DNW),
        .DEN_W (SUMW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    always_comb begin
        ext_i = (AW+IDX_W)'(r_ii);
        ext_j = (AW+IDX_W)'(r_ij);
        ext_k = (AW+IDX_W)'(r_ik);
        case (i_cmd.ra)
            RA_I:    ram_raddr = ext_i[AW-1:0];
            RA_J:    ram_raddr = ext_j[AW-1:0];
            RA_K:    ram_raddr = ext_k[AW-1:0];
            default: ram_raddr = r_i[AW-1:0];
        endcase
        ram_we    = (i_cmd.op == DP_V_WB) || (i_cmd.op == DP_NORM_WB);
        ram_wdata = (i_cmd.op == DP_V_WB) ? rnd30 : RAW_W'(div_quo[TAP_W-1:0]);
    end

    gkg_ram #(
        .WIDTH (RAW_W),
        .DEPTH (MAX_TAPS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_i[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        oob_i   = CW'(r_ii) >= CW'(r_built);
        oob_j   = CW'(r_ij) >= CW'(r_built);
        oob_k   = CW'(r_ik) >= CW'(r_built);
        rng_err = oob_i || (o_sts.use_j && oob_j) || (o_sts.use_k && oob_k);
    end

    always_comb begin
        o_sts.n_stop   = (r_n == '0) || (r_en == '0);
        o_sts.k_last   = (r_k == 4'(TAYLOR_TERMS));
        o_sts.i_last   = (r_i == r_size - SW'(1));
        o_sts.div_done = div_done;
        o_sts.use_j    = (r_dim >= 2'd2);
        o_sts.use_k    = (r_dim == 2'd3);
        o_sts.rd_err   = !r_ready || rng_err;
    end

    // control state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks    <= KERNEL_SIZE_RST;
            r_scale <= EXP_SCALE_RST;
            r_dims  <= DIMENSIONS_RST;
            r_ready <= 1'b0;
            r_built <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KERNEL_SIZE: r_ks    <= i_cfg_data[SIZE_W-1:0];
                    CFG_EXP_SCALE:   r_scale <= i_cfg_data[SCALE_W-1:0];
                    CFG_DIMENSIONS:  r_dims  <= i_cfg_data[DIMS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.op == DP_BDONE) begin
                r_ready <= 1'b1;
                r_built <= r_size;
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LATCH: begin
                r_ii  <= i_index_i;
                r_ij  <= i_index_j;
                r_ik  <= i_index_k;
                r_dim <= (r_dims == '0) ? 2'd1 : r_dims;
            end
            DP_BINIT: begin
                r_size <= size_c;
                r_i    <= '0;
                r_sum  <= '0;
            end
            DP_MUL_DD, DP_MUL_T, DP_MUL_EN, DP_MUL_TX, DP_DIV_TERM, DP_MUL_V,
            DP_MUL_P: begin
                r_prod <= mul_res;
            end
            DP_LOAD_T: begin
                r_n    <= NW'(r_prod[TW-1:16]);
                r_x    <= {r_prod[15:0], 14'b0};
                r_en   <= Q30_ONE;
                r_er   <= Q30_ONE;
                r_term <= Q30_ONE;
                r_k    <= 4'd1;
            end
            DP_EN_WB: begin
                r_en <= rnd30;
                r_n  <= r_n - NW'(1);
            end
            DP_TERM_WB: begin
                r_term <= quo31;
                r_er   <= r_k[0] ? (r_er - quo31) : (r_er + quo31);
                r_k    <= r_k + 4'd1;
            end
            DP_V_WB: begin
                r_sum <= r_sum + SUMW'(rnd30);
                r_i   <= r_i + SW'(1);
            end
            DP_NINIT: begin
                r_i <= '0;
            end
            DP_NORM_WB: begin
                r_i <= r_i + SW'(1);
            end
            DP_BDONE: begin
                r_p  <= '0;
                r_st <= ST_OK;
            end
            DP_RCHK: begin
                r_p <= '0;
                if (!r_ready) begin
                    r_st <= ST_NOT_BUILT;
                end else if (rng_err) begin
                    r_st <= ST_RANGE;
                end else begin
                    r_st <= ST_OK;
                end
            end
            DP_P_LOAD: begin
                r_p <= ram_rdata[TAP_W-1:0];
            end
            DP_P_WB: begin
                r_p <= rnd16;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_coef   <= r_p;
            r_status <= r_st;
        end
    end

    assign o_coefficient = r_coef;
    assign o_status      = r_status;

endmodule

`default_nettype wire

[src/gkg_ctrl.sv]
// ----------------------------------------------------------------------------
// gkg_ctrl
// Controller: sequences table builds and coefficient reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gkg_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_opcode,
    input  wire logic             i_out_stall,
    input  wire gkg_pkg::t_dp_sts i_sts,
    output gkg_pkg::t_dp_cmd      o_cmd,
    output logic                  o_in_stall,
    output logic                  o_out_valid
);

    import gkg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RCHK, S_RA0, S_RA1, S_RA2, S_RW1, S_RM2, S_RW2,
        S_BINIT, S_DD, S_T, S_TLD, S_EN, S_EN_WB, S_TM, S_TD, S_TW,
        S_V, S_VW, S_NINIT, S_NRD, S_NDIV, S_NW, S_BDONE, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = DP_NOP;
        o_cmd.ra       = RA_TAP;
        o_cmd.out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LATCH;
                    n_state  = (i_opcode == OP_READ) ? S_RCHK : S_BINIT;
                end
            end
            S_RCHK: begin
                o_cmd.op = DP_RCHK;
                n_state  = i_sts.rd_err ? S_DONE : S_RA0;
            end
            S_RA0: begin
                o_cmd.ra = RA_I;
                n_state  = S_RA1;
            end
            S_RA1: begin
                o_cmd.op = DP_P_LOAD;
                o_cmd.ra = RA_J;
                n_state  = i_sts.use_j ? S_RA2 : S_DONE;
            end
            S_RA2: begin
                o_cmd.op = DP_MUL_P;
                o_cmd.ra = RA_K;
                n_state  = S_RW1;
            end
            S_RW1: begin
                o_cmd.op = DP_P_WB;
                o_cmd.ra = RA_K;
                n_state  = i_sts.use_k ? S_RM2 : S_DONE;
            end
            S_RM2: begin
                o_cmd.op = DP_MUL_P;
                o_cmd.ra = RA_K;
                n_state  = S_RW2;
            end
            S_RW2: begin
                o_cmd.op = DP_P_WB;
                n_state  = S_DONE;
            end
            S_BINIT: begin
                o_cmd.op = DP_BINIT;
                n_state  = S_DD;
            end
            S_DD: begin
                o_cmd.op = DP_MUL_DD;
                n_state  = S_T;
            end
            S_T: begin
                o_cmd.op = DP_MUL_T;
                n_state  = S_TLD;
            end
            S_TLD: begin
                o_cmd.op = DP_LOAD_T;
                n_state  = S_EN;
            end
            // integer part: repeated multiply by 1/e
            S_EN: begin
                if (i_sts.n_stop) begin
                    n_state = S_TM;
                end else begin
                    o_cmd.op = DP_MUL_EN;
                    n_state  = S_EN_WB;
                end
            end
            S_EN_WB: begin
                o_cmd.op = DP_EN_WB;
                n_state  = S_EN;
            end
            // fraction part: taylor series, one term per pass
            S_TM: begin
                o_cmd.op = DP_MUL_TX;
                n_state  = S_TD;
            end
            S_TD: begin
                o_cmd.op = DP_DIV_TERM;
                n_state  = S_TW;
            end
            S_TW: begin
                o_cmd.op = DP_TERM_WB;
                n_state  = i_sts.k_last ? S_V : S_TM;
            end
            S_V: begin
                o_cmd.op = DP_MUL_V;
                n_state  = S_VW;
            end
            S_VW: begin
                o_cmd.op = DP_V_WB;
                n_state  = i_sts.i_last ? S_NINIT : S_DD;
            end
            // normalize pass over the stored raw taps
            S_NINIT: begin
                o_cmd.op = DP_NINIT;
                n_state  = S_NRD;
            end
            S_NRD: begin
                n_state = S_NDIV;
            end
            S_NDIV: begin
                o_cmd.op = DP_DIV_NORM;
                n_state  = S_NW;
            end
            S_NW: begin
                if (i_sts.div_done) begin
                    o_cmd.op = DP_NORM_WB;
                    n_state  = i_sts.i_last ? S_BDONE : S_NRD;
                end
            end
            S_BDONE: begin
                o_cmd.op = DP_BDONE;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[src/gaussian_kernel_generator_unit.sv]
// ----------------------------------------------------------------------------
// gaussian_kernel_generator_unit
// Normalized gaussian kernel: builds a Q1.16 tap table, reads 1D/2D/3D taps.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  cfg      in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//  in       in         i_in_valid / o_in_stall   i_opcode, i_index_i/j/k
//  out      out        o_out_valid / i_out_stall o_coefficient, o_status
//
//  read item: longer for 2D and 3D than for 1D, set by the one table read
//  port and the shared multiplier; a range or not-built error ends it early.
//  build item: per tap an exponent by repeated multiply by 1/e and a taylor
//  series, then a normalization pass with the bit-serial divider per tap.
//  reset is synchronous, sets config to its reset values and clears the built
//  flag and the controller.
//  a finished result waits in the output register while the next item enters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gaussian_kernel_generator_unit #(
    parameter int MAX_TAPS = gkg_pkg::MAX_TAPS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [gkg_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [gkg_pkg::CFG_DW-1:0]  i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_opcode,
    input  wire logic [gkg_pkg::IDX_W-1:0]   i_index_i,
    input  wire logic [gkg_pkg::IDX_W-1:0]   i_index_j,
    input  wire logic [gkg_pkg::IDX_W-1:0]   i_index_k,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [gkg_pkg::TAP_W-1:0]   o_coefficient,
    output logic      [1:0]                  o_status
);

    import gkg_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    gkg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    gkg_dp #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_index_i     (i_index_i),
        .i_index_j     (i_index_j),
        .i_index_k     (i_index_k),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_coefficient (o_coefficient),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

[src/gkg_chk.sv]
// ----------------------------------------------------------------------------
// gkg_chk
// Port-level checks of the gaussian kernel generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gkg_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_cfg_valid,
    input wire logic                        o_cfg_ready,
    input wire logic [gkg_pkg::CFG_IW-1:0]  i_cfg_index,
    input wire logic [gkg_pkg::CFG_DW-1:0]  i_cfg_data,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        i_opcode,
    input wire logic [gkg_pkg::IDX_W-1:0]   i_index_i,
    input wire logic [gkg_pkg::IDX_W-1:0]   i_index_j,
    input wire logic [gkg_pkg::IDX_W-1:0]   i_index_k,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [gkg_pkg::TAP_W-1:0]   o_coefficient,
    input wire logic [1:0]                  o_status
);

    import gkg_pkg::*;

    // one item at a time: an accepted item closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in flight");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_coefficient == '0))
        else $error("error result with nonzero coefficient");

    a_coef_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_coefficient <= 17'd65536))
        else $error("coefficient above one");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_NOT_BUILT
                         || o_status == ST_RANGE))
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_coefficient) && $stable(o_status)))
        else $error("stalled item changed");

endmodule

bind gaussian_kernel_generator_unit gkg_chk u_gkg_chk (.*);

`default_nettype wire

[verif/gaussian_kernel_generator_unit_checker.sv]
// ----------------------------------------------------------------------------
// gaussian_kernel_generator_unit_checker
// Watches the config, input and output channels of the kernel generator,
// keeps its own tap table and registers, predicts each result and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_kernel_generator_unit_checker #(
    parameter int MAX_TAPS = gkg_pkg::MAX_TAPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [gkg_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [gkg_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_opcode,
    input  logic [gkg_pkg::IDX_W-1:0]   i_index_i,
    input  logic [gkg_pkg::IDX_W-1:0]   i_index_j,
    input  logic [gkg_pkg::IDX_W-1:0]   i_index_k,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [gkg_pkg::TAP_W-1:0]   i_coefficient,
    input  logic [1:0]                  i_status,
    output int                          o_fail_count,
    output int                          o_pending
);

    import gkg_pkg::*;

    typedef struct {
        logic [TAP_W-1:0] coefficient;
        t_status          status;
    } t_weight;

    t_weight            weights_due[$];
    logic [TAP_W-1:0]   taps [MAX_TAPS];
    logic               taps_valid;
    logic [SIZE_W-1:0]  taps_count;
    logic [SIZE_W-1:0]  size_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [DIMS_W-1:0]  dims_reg;
    int                 fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = weights_due.size();

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // exp(-t), t in Q16, result in Q30
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
        logic [63:0] n;
        logic [63:0] x;
        logic [63:0] en;
        logic [63:0] term;
        logic [63:0] er;
        n    = t >> 16;
        x    = (t & 64'hFFFF) << 14;
        en   = 64'(Q30_ONE);
        term = 64'(Q30_ONE);
        er   = 64'(Q30_ONE);
        while (n > 0 && en != 0) begin
            en = (en * 64'(E_INV_Q30) + (64'd1 << 29)) >> 30;
            n--;
        end
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = ((term * x) >> 30) / k;
            if (k % 2 == 1) er = er - term;
            else            er = er + term;
        end
        return (en * er + (64'd1 << 29)) >> 30;
    endfunction

    task automatic build_taps();
        logic [63:0] raw [MAX_TAPS];
        logic [63:0] total;
        int          size;
        int          center;
        int          d;
        total = 0;
        size  = size_reg;
        if (size == 0) size = 1;
        if (size > MAX_TAPS) size = MAX_TAPS;
        center = (size + 1) / 2 - 1;
        for (int i = 0; i < size; i++) begin
            d = i - center;
            raw[i] = exp_neg_q30(64'(d * d) * 64'(scale_reg));
            total += raw[i];
        end
        for (int i = 0; i < size; i++)
            taps[i] = TAP_W'(((raw[i] << 16) + total / 2) / total);
        taps_count = SIZE_W'(size);
        taps_valid = 1'b1;
    endtask

    function automatic t_weight predict_weight(input logic op, input logic [IDX_W-1:0] ii,
                                               input logic [IDX_W-1:0] jj,
                                               input logic [IDX_W-1:0] kk);
        t_weight     w;
        int          dims;
        logic [63:0] p;
        logic [IDX_W-1:0] idx [3];
        w.coefficient = '0;
        w.status      = ST_OK;
        if (t_opcode'(op) == OP_BUILD) return w;
        if (!taps_valid) begin
            w.status = ST_NOT_BUILT;
            return w;
        end
        dims   = (dims_reg == 0) ? 1 : dims_reg;
        idx[0] = ii;
        idx[1] = jj;
        idx[2] = kk;
        for (int a = 0; a < dims; a++) begin
            if (idx[a] >= taps_count) begin
                w.status = ST_RANGE;
                return w;
            end
        end
        p = 64'(taps[idx[0]]);
        for (int a = 1; a < dims; a++)
            p = (p * 64'(taps[idx[a]]) + 64'd32768) >> 16;
        w.coefficient = TAP_W'(p);
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_weight w;
        if (!i_rst_n) begin
            taps_valid <= 1'b0;
            taps_count <= '0;
            size_reg   <= KERNEL_SIZE_RST;
            scale_reg  <= EXP_SCALE_RST;
            dims_reg   <= DIMENSIONS_RST;
            weights_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_KERNEL_SIZE: size_reg  <= i_cfg_data[SIZE_W-1:0];
                    CFG_EXP_SCALE:   scale_reg <= i_cfg_data[SCALE_W-1:0];
                    CFG_DIMENSIONS:  dims_reg  <= i_cfg_data[DIMS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                w = predict_weight(i_opcode, i_index_i, i_index_j, i_index_k);
                if (t_opcode'(i_opcode) == OP_BUILD) build_taps();
                weights_due.push_back(w);
            end
            if (i_out_valid && !i_out_stall) begin
                if (weights_due.size() == 0) begin
                    report_mismatch("unexpected result, status", i_status, 0);
                end else begin
                    w = weights_due.pop_front();
                    if (i_coefficient !== w.coefficient)
                        report_mismatch("coefficient", i_coefficient, w.coefficient);
                    if (i_status !== w.status)
                        report_mismatch("status", i_status, w.status);
                end
            end
        end
    end

endmodule

[verif/gaussian_kernel_generator_unit_test.sv]
// ----------------------------------------------------------------------------
// gaussian_kernel_generator_unit_test
// Directed and random build/read items over several kernel settings, with
// random idling on both channels; a side checker predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_kernel_generator_unit_test;
    import gkg_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_opcode = 1'b0;
    logic [IDX_W-1:0]  i_index_i = '0;
    logic [IDX_W-1:0]  i_index_j = '0;
    logic [IDX_W-1:0]  i_index_k = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [TAP_W-1:0]  o_coefficient;
    logic [1:0]        o_status;

    int  fail_count;
    int  pending;
    int  cycles = 0;
    bit  quiet = 1'b0;
    int  cur_size = 5;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    gaussian_kernel_generator_unit dut (.*);

    gaussian_kernel_generator_unit_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_in_valid, .i_in_stall(o_in_stall), .i_opcode, .i_index_i,
        .i_index_j, .i_index_k, .i_out_valid(o_out_valid), .i_out_stall,
        .i_coefficient(o_coefficient), .i_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 32);
    end

    task automatic send_item(input t_opcode op, input int ii, input int jj, input int kk);
        if (!quiet && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_index_i  <= IDX_W'(ii);
        i_index_j  <= IDX_W'(jj);
        i_index_k  <= IDX_W'(kk);
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DW'(value);
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_KERNEL_SIZE) begin
            cur_size = (value % 64 == 0) ? 1 : ((value % 64 > 32) ? 32 : value % 64);
        end
    endtask

    task automatic set_kernel(input int size, input int scale, input int dims);
        drain();
        write_reg(CFG_KERNEL_SIZE, size);
        write_reg(CFG_EXP_SCALE, scale);
        write_reg(CFG_DIMENSIONS, dims);
    endtask

    // mostly in range, now and then past the built size
    function automatic int pick_index();
        if ($urandom_range(99) < 85) return $urandom_range(cur_size - 1);
        return $urandom_range(31);
    endfunction

    initial begin
        int size;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // read before any build
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_BUILD, 31, 31, 31);
        for (int i = 0; i <= 5; i++) send_item(OP_READ, i, 31, 31);
        send_item(OP_READ, 31, 0, 0);
        set_kernel(5, 31457, 0);
        send_item(OP_READ, 2, 31, 31);
        drain();
        write_reg(CFG_DIMENSIONS, 2);
        send_item(OP_READ, 2, 2, 31);
        send_item(OP_READ, 1, 5, 0);
        drain();
        write_reg(CFG_DIMENSIONS, 3);
        send_item(OP_READ, 2, 2, 2);
        send_item(OP_READ, 0, 4, 7);
        // size zero builds a single tap
        set_kernel(0, 1048575, 3);
        send_item(OP_BUILD, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0);
        send_item(OP_READ, 0, 1, 0);
        // oversize saturates, flat taps
        set_kernel(63, 0, 3);
        send_item(OP_BUILD, 0, 0, 0);
        send_item(OP_READ, 31, 31, 31);
        send_item(OP_READ, 0, 15, 16);
        set_kernel(32, 1048575, 1);
        send_item(OP_BUILD, 0, 0, 0);
        send_item(OP_READ, 15, 0, 0);
        send_item(OP_READ, 31, 0, 0);

        for (int phase = 0; phase < 20; phase++) begin
            quiet = (phase >= 8 && phase < 11);
            case ($urandom_range(9))
                0:       size = $urandom_range(33, 63);
                1:       size = (phase == 13) ? 32 : 0;
                default: size = $urandom_range(1, 9);
            endcase
            set_kernel(size, ($urandom_range(3) == 0) ? $urandom_range(20'hFFFFF)
                                                       : $urandom_range(200000),
                       $urandom_range(3));
            if (phase == 5) send_item(OP_READ, 0, 0, 0);   // stale table, new registers
            send_item(OP_BUILD, $urandom_range(31), $urandom_range(31), $urandom_range(31));
            for (int n = 0; n < 52; n++) begin
                if (n == 26) begin
                    drain();
                    write_reg(CFG_DIMENSIONS, $urandom_range(3));
                end
                send_item(OP_READ, pick_index(), pick_index(), pick_index());
            end
        end
        quiet = 1'b0;

        drain();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
